FILE: rtl/core/sfba_pkg.sv
`default_nettype none

package sfba_pkg;

   // Number of segments that have registers; segments beyond this are never walked.
   localparam int REG_SEGS = 4;
   localparam int SEG_IDX_W = 2;

   localparam int BLOCK_W = 16;
   localparam int TOTAL_W = 19;
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 16;
   localparam int STATUS_W = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 19;

   // Segment zero starts at handle 2^FIRST_BASE_SHIFT.
   localparam int FIRST_BASE_SHIFT = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register indexes: block sizes come first, then the segment totals.
   localparam logic [CSR_INDEX_W-1:0] CSR_SEG0_BLOCK_BYTES = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEG0_TOTAL_BYTES = 3'd4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

   typedef logic [BLOCK_W-1:0] block_array_type [REG_SEGS];
   typedef logic [TOTAL_W-1:0] total_array_type [REG_SEGS];
   typedef logic [COUNT_W-1:0] count_array_type [REG_SEGS];

   localparam block_array_type BLOCK_RESET = '{16'd16, 16'd32, 16'd64, 16'd128};

   // Compare results of the shared bound unit.
   typedef struct packed {
      logic fits;
      logic in_range;
   } cmp_result_type;

endpackage

`default_nettype wire

FILE: rtl/core/segmented_fixed_block_allocator_core.sv
`default_nettype none

// Fixed-block allocator over up to four segments of handle space. One command is
// taken while busy is low; its result is strobed on rsp_valid for one cycle and
// must be taken in that cycle, since the receiver cannot stall. The next command
// may be started in that same cycle. The command walks the segments one per cycle
// through a single add-and-compare unit, then goes to a free step for a free, to
// an allocate step and a count step for an allocate served from the pool, or to
// an allocate step, a pop step and a count step for an allocate served from the
// free list, whose link is read from a synchronous RAM. An allocate whose segment
// has an empty free list and an exhausted pool ends in its allocate step, and a
// command that finds no segment ends after the walk. Any register write clears all
// segment state at once; no clearing pass is needed.
module segmented_fixed_block_allocator_core #(
   parameter int NUM_SEGMENTS  = 4,
   parameter int HANDLE_BITS   = 16,
   parameter int GRANULE_SHIFT = 3
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_func,
   input  wire logic [sfba_pkg::FIELD_W-1:0]     req_request_bytes,
   input  wire logic [sfba_pkg::FIELD_W-1:0]     req_free_handle,
   output logic                                  rsp_valid,
   output logic [sfba_pkg::FIELD_W-1:0]          rsp_result_handle,
   output logic [sfba_pkg::SEG_IDX_W-1:0]        rsp_segment_index,
   output logic [sfba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [sfba_pkg::COUNT_W-1:0]          rsp_in_use,
   output logic [sfba_pkg::COUNT_W-1:0]          rsp_in_use_peak,
   input  wire logic                             csr_we,
   input  wire logic [sfba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sfba_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfba_pkg::*;

   localparam int ACTIVE_SEGS = (NUM_SEGMENTS < REG_SEGS) ? NUM_SEGMENTS : REG_SEGS;
   localparam logic [SEG_IDX_W-1:0] LAST_SEG = SEG_IDX_W'(ACTIVE_SEGS - 1);
   localparam logic [HANDLE_BITS-1:0] HANDLE_LIMIT = '1;
   localparam logic [HANDLE_BITS-1:0] FIRST_BASE =
      (FIRST_BASE_SHIFT < HANDLE_BITS) ? HANDLE_BITS'(1 << FIRST_BASE_SHIFT) : HANDLE_LIMIT;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_ALLOC = 3'd2;
   localparam logic [2:0] ST_POP   = 3'd3;
   localparam logic [2:0] ST_COUNT = 3'd4;
   localparam logic [2:0] ST_FREE  = 3'd5;

   typedef logic [HANDLE_BITS-1:0] handle_array_type [REG_SEGS];

   logic [2:0]             state_ff, state_in;
   logic [SEG_IDX_W-1:0]   seg_ff, seg_in;
   logic [HANDLE_BITS-1:0] base_ff, base_in;
   logic [HANDLE_BITS-1:0] ceil_ff, ceil_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic                   func_ff, func_in;
   logic [FIELD_W-1:0]     req_bytes_ff, req_bytes_in;
   logic [FIELD_W-1:0]     free_handle_ff, free_handle_in;

   block_array_type        block_ff, block_in;
   total_array_type        total_ff, total_in;
   handle_array_type       pool_ff, pool_in;
   handle_array_type       head_ff, head_in;
   count_array_type        count_ff, count_in;
   count_array_type        peak_ff, peak_in;
   logic [REG_SEGS-1:0]    fresh_ff, fresh_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [SEG_IDX_W-1:0]   rsp_seg_ff, rsp_seg_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_used_ff, rsp_used_in;
   logic [COUNT_W-1:0]     rsp_peak_ff, rsp_peak_in;

   logic [HANDLE_BITS-1:0] cur_pool;
   logic [HANDLE_BITS-1:0] cur_head;
   logic [COUNT_W-1:0]     cur_count;
   logic [COUNT_W-1:0]     cur_peak;
   logic [COUNT_W-1:0]     up_count;
   logic [COUNT_W-1:0]     down_count;

   logic [HANDLE_BITS-1:0] unit_base;
   logic [TOTAL_W-1:0]     unit_span;
   logic [HANDLE_BITS-1:0] unit_end;
   cmp_result_type         unit_cmp;
   logic                   walk_hit;

   logic                   link_we;
   logic [HANDLE_BITS-1:0] link_rdata;

   // A segment whose pool has not moved since the last clear gives out its base.
   assign cur_pool   = fresh_ff[seg_ff] ? base_ff : pool_ff[seg_ff];
   assign cur_head   = head_ff[seg_ff];
   assign cur_count  = count_ff[seg_ff];
   assign cur_peak   = peak_ff[seg_ff];
   assign up_count   = (cur_count < COUNT_MAX) ? cur_count + 1'b1 : cur_count;
   assign down_count = (cur_count != '0) ? cur_count - 1'b1 : cur_count;

   // The walk feeds segment totals; the allocate step feeds the pool and block size.
   assign unit_base = (state_ff == ST_ALLOC) ? cur_pool : base_ff;
   assign unit_span = (state_ff == ST_ALLOC) ? TOTAL_W'(block_ff[seg_ff] >> GRANULE_SHIFT)
                                             : (total_ff[seg_ff] >> GRANULE_SHIFT);

   sfba_bound_unit #(
      .HANDLE_BITS(HANDLE_BITS)
   ) u_bound_unit (
      .base_handle   (unit_base),
      .span_granules (unit_span),
      .probe_handle  (free_handle_ff),
      .size_have     (block_ff[seg_ff]),
      .size_want     (req_bytes_ff),
      .end_handle    (unit_end),
      .cmp           (unit_cmp)
   );

   assign walk_hit = (func_ff == FUNC_FREE) ? unit_cmp.in_range : unit_cmp.fits;

   assign link_we = (state_ff == ST_FREE);

   sfba_link_ram #(
      .ADDR_W(HANDLE_BITS),
      .DATA_W(HANDLE_BITS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (free_handle_ff[HANDLE_BITS-1:0]),
      .wdata (cur_head),
      .raddr (cur_head),
      .rdata (link_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      seg_in         = seg_ff;
      base_in        = base_ff;
      ceil_in        = ceil_ff;
      handle_in      = handle_ff;
      func_in        = func_ff;
      req_bytes_in   = req_bytes_ff;
      free_handle_in = free_handle_ff;
      block_in       = block_ff;
      total_in       = total_ff;
      pool_in        = pool_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      peak_in        = peak_ff;
      fresh_in       = fresh_ff;
      rsp_valid_in   = 1'b0;
      rsp_handle_in  = rsp_handle_ff;
      rsp_seg_in     = rsp_seg_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_peak_in    = rsp_peak_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in       = ST_WALK;
               seg_in         = '0;
               base_in        = FIRST_BASE;
               func_in        = req_func;
               req_bytes_in   = req_request_bytes;
               free_handle_in = req_free_handle;
            end
         end
         ST_WALK: begin
            if (walk_hit) begin
               ceil_in  = unit_end;
               state_in = (func_ff == FUNC_FREE) ? ST_FREE : ST_ALLOC;
            end else if (seg_ff == LAST_SEG) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_seg_in    = '0;
               rsp_status_in = (func_ff == FUNC_FREE) ? STATUS_OUTSIDE : STATUS_NO_FIT;
               rsp_used_in   = '0;
               rsp_peak_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               base_in = unit_end;
               seg_in  = seg_ff + 1'b1;
            end
         end
         ST_ALLOC: begin
            if (cur_head != '0) begin
               // The link RAM is reading the head's successor during this cycle.
               handle_in = cur_head;
               state_in  = ST_POP;
            end else if (cur_pool < ceil_ff) begin
               handle_in        = cur_pool;
               pool_in[seg_ff]  = unit_end;
               fresh_in[seg_ff] = 1'b0;
               state_in         = ST_COUNT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_seg_in    = seg_ff;
               rsp_status_in = STATUS_NO_FIT;
               rsp_used_in   = cur_count;
               rsp_peak_in   = cur_peak;
               state_in      = ST_IDLE;
            end
         end
         ST_POP: begin
            head_in[seg_ff] = link_rdata;
            state_in        = ST_COUNT;
         end
         ST_COUNT: begin
            count_in[seg_ff] = up_count;
            peak_in[seg_ff]  = (up_count > cur_peak) ? up_count : cur_peak;
            rsp_valid_in     = 1'b1;
            rsp_handle_in    = FIELD_W'(handle_ff);
            rsp_seg_in       = seg_ff;
            rsp_status_in    = STATUS_OK;
            rsp_used_in      = up_count;
            rsp_peak_in      = (up_count > cur_peak) ? up_count : cur_peak;
            state_in         = ST_IDLE;
         end
         ST_FREE: begin
            head_in[seg_ff]  = free_handle_ff[HANDLE_BITS-1:0];
            count_in[seg_ff] = down_count;
            rsp_valid_in     = 1'b1;
            rsp_handle_in    = '0;
            rsp_seg_in       = seg_ff;
            rsp_status_in    = STATUS_OK;
            rsp_used_in      = down_count;
            rsp_peak_in      = cur_peak;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Redefining any segment puts every segment back to its empty state.
      if (csr_we) begin
         if (csr_index < CSR_SEG0_TOTAL_BYTES) begin
            block_in[csr_index[SEG_IDX_W-1:0]] = csr_wdata[BLOCK_W-1:0];
         end else begin
            total_in[csr_index[SEG_IDX_W-1:0]] = csr_wdata[TOTAL_W-1:0];
         end
         head_in  = '{default: '0};
         count_in = '{default: '0};
         peak_in  = '{default: '0};
         fresh_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         block_ff     <= BLOCK_RESET;
         total_ff     <= '{default: '0};
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         peak_ff      <= '{default: '0};
         fresh_ff     <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         block_ff     <= block_in;
         total_ff     <= total_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff         <= seg_in;
      base_ff        <= base_in;
      ceil_ff        <= ceil_in;
      handle_ff      <= handle_in;
      func_ff        <= func_in;
      req_bytes_ff   <= req_bytes_in;
      free_handle_ff <= free_handle_in;
      pool_ff        <= pool_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_seg_ff     <= rsp_seg_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_peak_ff    <= rsp_peak_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_segment_index = rsp_seg_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_in_use        = rsp_used_ff;
   assign rsp_in_use_peak   = rsp_peak_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sfba_bound_unit.sv
`default_nettype none

module sfba_bound_unit #(
   parameter int HANDLE_BITS = 16
) (
   input  wire logic [HANDLE_BITS-1:0]       base_handle,
   input  wire logic [sfba_pkg::TOTAL_W-1:0] span_granules,
   input  wire logic [sfba_pkg::FIELD_W-1:0] probe_handle,
   input  wire logic [sfba_pkg::BLOCK_W-1:0] size_have,
   input  wire logic [sfba_pkg::FIELD_W-1:0] size_want,
   output logic [HANDLE_BITS-1:0]            end_handle,
   output sfba_pkg::cmp_result_type          cmp
);
   import sfba_pkg::*;

   localparam int SUM_W = ((HANDLE_BITS > TOTAL_W) ? HANDLE_BITS : TOTAL_W) + 1;
   localparam logic [HANDLE_BITS-1:0] HANDLE_LIMIT = '1;

   logic [SUM_W-1:0] sum_full;

   // One add with clipping at the largest handle serves both segment ceilings and
   // pool advances.
   assign sum_full = SUM_W'(base_handle) + SUM_W'(span_granules);
   assign end_handle = (sum_full > SUM_W'(HANDLE_LIMIT)) ? HANDLE_LIMIT
                                                         : sum_full[HANDLE_BITS-1:0];

   assign cmp.fits = (FIELD_W'(size_have) >= size_want);
   assign cmp.in_range = (probe_handle >= FIELD_W'(base_handle)) &&
                         (probe_handle < FIELD_W'(end_handle)) &&
                         (probe_handle != '0);

endmodule

`default_nettype wire

FILE: rtl/core/sfba_link_ram.sv
`default_nettype none

module sfba_link_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0]      rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/sfba_checker.sv
`default_nettype none

module sfba_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_valid,
   input wire logic [sfba_pkg::FIELD_W-1:0]     rsp_result_handle,
   input wire logic [sfba_pkg::SEG_IDX_W-1:0]   rsp_segment_index,
   input wire logic [sfba_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic [sfba_pkg::COUNT_W-1:0]     rsp_in_use,
   input wire logic [sfba_pkg::COUNT_W-1:0]     rsp_in_use_peak
);
   import sfba_pkg::*;

   // An accepted command always raises busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // Idle never sets the strobe, so result words never come back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // A handed-out block has been counted as in use.
   a_alloc_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_handle != '0) |->
         (rsp_status == STATUS_OK) && (rsp_in_use != '0))
      else $error("allocated handle without an in-use count");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_in_use <= rsp_in_use_peak)
      else $error("in-use count above its high-water mark");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OUTSIDE) |->
         (rsp_result_handle == '0) && (rsp_segment_index == '0) &&
         (rsp_in_use == '0) && (rsp_in_use_peak == '0))
      else $error("free outside every segment reported nonzero fields");

endmodule

bind segmented_fixed_block_allocator_core sfba_checker u_sfba_checker (.*);

`default_nettype wire

FILE: tb/tb_segmented_fixed_block_allocator_core.sv
`timescale 1ns / 100ps

module tb_segmented_fixed_block_allocator_core;
   import sfba_pkg::*;

   localparam int NUM_SEGMENTS  = 4;
   localparam int HANDLE_BITS   = 16;
   localparam int GRANULE_SHIFT = 3;
   localparam int ACTIVE_SEGS   = (NUM_SEGMENTS < REG_SEGS) ? NUM_SEGMENTS : REG_SEGS;
   localparam int unsigned HANDLE_LIMIT = (1 << HANDLE_BITS) - 1;
   localparam int unsigned CYCLE_LIMIT  = 2000000;

   typedef struct packed {
      logic               func;
      logic [FIELD_W-1:0] req_bytes;
      logic [FIELD_W-1:0] handle;
   } cmd_word_type;

   typedef struct packed {
      logic [FIELD_W-1:0]   handle;
      logic [SEG_IDX_W-1:0] seg;
      logic [STATUS_W-1:0]  status;
      logic [COUNT_W-1:0]   used;
      logic [COUNT_W-1:0]   peak;
   } reply_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_func = FUNC_ALLOC;
   logic [FIELD_W-1:0]     req_request_bytes = '0;
   logic [FIELD_W-1:0]     req_free_handle = '0;
   logic                   rsp_valid;
   logic [FIELD_W-1:0]     rsp_result_handle;
   logic [SEG_IDX_W-1:0]   rsp_segment_index;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_W-1:0]     rsp_in_use;
   logic [COUNT_W-1:0]     rsp_in_use_peak;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Local copy of the allocator: layout registers and per-segment state.
   int unsigned blk_bytes [REG_SEGS];
   int unsigned tot_bytes [REG_SEGS];
   int unsigned pool_ptr [REG_SEGS];
   int unsigned free_top [REG_SEGS];
   int unsigned used_cnt [REG_SEGS];
   int unsigned used_peak [REG_SEGS];
   logic [FIELD_W-1:0] link_mem [65536];

   cmd_word_type command_fifo[$];
   reply_type    pending_replies[$];
   cmd_word_type active_cmd;
   reply_type    want_reply;
   int           gap_pct = 0;
   bit           drain_hold = 1'b0;
   int unsigned  fault_count = 0;
   int unsigned  cycle_count = 0;

   segmented_fixed_block_allocator_core #(
      .NUM_SEGMENTS  (NUM_SEGMENTS),
      .HANDLE_BITS   (HANDLE_BITS),
      .GRANULE_SHIFT (GRANULE_SHIFT)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_request_bytes (req_request_bytes),
      .req_free_handle   (req_free_handle),
      .rsp_valid         (rsp_valid),
      .rsp_result_handle (rsp_result_handle),
      .rsp_segment_index (rsp_segment_index),
      .rsp_status        (rsp_status),
      .rsp_in_use        (rsp_in_use),
      .rsp_in_use_peak   (rsp_in_use_peak),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned clip_handle(int unsigned v);
      return (v > HANDLE_LIMIT) ? HANDLE_LIMIT : v;
   endfunction

   // Segments are packed back to back starting at handle 1024.
   function automatic void seg_span(input int s, output int unsigned lo, output int unsigned hi);
      lo = clip_handle(1 << FIRST_BASE_SHIFT);
      hi = lo;
      for (int i = 0; i <= s; i++) begin
         lo = hi;
         hi = clip_handle(lo + (tot_bytes[i] >> GRANULE_SHIFT));
      end
   endfunction

   function automatic void clear_segments();
      int unsigned lo;
      int unsigned hi;
      for (int s = 0; s < REG_SEGS; s++) begin
         seg_span(s, lo, hi);
         pool_ptr[s] = lo;
         free_top[s] = 0;
         used_cnt[s] = 0;
         used_peak[s] = 0;
      end
   endfunction

   function automatic reply_type predict_allocator(cmd_word_type c);
      reply_type   r;
      int unsigned lo;
      int unsigned hi;
      int          seg;
      bit          hit;
      r = '0;
      r.status = STATUS_NO_FIT;
      seg = 0;
      hit = 1'b0;
      if (c.func == FUNC_ALLOC) begin
         for (int s = 0; s < ACTIVE_SEGS && !hit; s++) begin
            if (blk_bytes[s] >= c.req_bytes) begin
               seg = s;
               hit = 1'b1;
            end
         end
         if (hit) begin
            seg_span(seg, lo, hi);
            if (free_top[seg] != 0) begin
               r.handle = FIELD_W'(free_top[seg]);
               free_top[seg] = link_mem[r.handle];
            end else if (pool_ptr[seg] < hi) begin
               r.handle = FIELD_W'(pool_ptr[seg]);
               pool_ptr[seg] = clip_handle(pool_ptr[seg] + (blk_bytes[seg] >> GRANULE_SHIFT));
            end
            if (r.handle != 0) begin
               r.status = STATUS_OK;
               if (used_cnt[seg] < COUNT_MAX) used_cnt[seg]++;
               if (used_cnt[seg] > used_peak[seg]) used_peak[seg] = used_cnt[seg];
            end
            r.seg = SEG_IDX_W'(seg);
            r.used = COUNT_W'(used_cnt[seg]);
            r.peak = COUNT_W'(used_peak[seg]);
         end
      end else begin
         r.status = STATUS_OUTSIDE;
         for (int s = 0; s < ACTIVE_SEGS && !hit; s++) begin
            seg_span(s, lo, hi);
            if (c.handle >= lo && c.handle < hi) begin
               seg = s;
               hit = 1'b1;
            end
         end
         if (hit && c.handle != 0) begin
            link_mem[c.handle] = FIELD_W'(free_top[seg]);
            free_top[seg] = c.handle;
            if (used_cnt[seg] != 0) used_cnt[seg]--;
            r.status = STATUS_OK;
            r.seg = SEG_IDX_W'(seg);
            r.used = COUNT_W'(used_cnt[seg]);
            r.peak = COUNT_W'(used_peak[seg]);
         end
      end
      return r;
   endfunction

   function automatic cmd_word_type alloc_word(int unsigned bytes);
      cmd_word_type c;
      c.func = FUNC_ALLOC;
      c.req_bytes = FIELD_W'(bytes);
      c.handle = FIELD_W'($urandom_range(65535, 0));
      return c;
   endfunction

   function automatic cmd_word_type free_word(int unsigned h);
      cmd_word_type c;
      c.func = FUNC_FREE;
      c.req_bytes = FIELD_W'($urandom_range(65535, 0));
      c.handle = FIELD_W'(h);
      return c;
   endfunction

   // Mostly sizes near a block size and handles on block boundaries, so that
   // lists fill and drain; the rest is raw noise and out-of-range handles.
   function automatic cmd_word_type random_word();
      cmd_word_type c;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  step;
      int unsigned  k;
      int           s;
      int           pick;
      s = $urandom_range(REG_SEGS - 1, 0);
      pick = $urandom_range(9, 0);
      if ($urandom_range(99, 0) < 55) begin
         c = alloc_word($urandom_range(65535, 0));
         if (pick < 4) c.req_bytes = FIELD_W'(blk_bytes[s]);
         else if (pick < 7) c.req_bytes = FIELD_W'($urandom_range(blk_bytes[s], 0));
         else if (pick == 7) c.req_bytes = FIELD_W'(clip_handle(blk_bytes[s] + 1));
         else if (pick == 8) c.req_bytes = '0;
      end else begin
         c = free_word($urandom_range(65535, 0));
         seg_span(s, lo, hi);
         step = blk_bytes[s] >> GRANULE_SHIFT;
         if (pick < 8 && hi > lo) begin
            k = (step == 0) ? 0 : $urandom_range((hi - lo - 1) / step, 0);
            c.handle = FIELD_W'(lo + k * step);
         end else if (pick == 8) begin
            c.handle = FIELD_W'($urandom_range(1, 0) ? lo - 1 : hi);
         end
      end
      return c;
   endfunction

   task automatic queue_random(input int n);
      repeat (n) command_fifo.push_back(random_word());
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < CSR_SEG0_TOTAL_BYTES) blk_bytes[idx] = BLOCK_W'(val);
      else tot_bytes[idx - CSR_SEG0_TOTAL_BYTES] = TOTAL_W'(val);
      clear_segments();
   endtask

   task automatic set_layout(input int unsigned b0, b1, b2, b3, t0, t1, t2, t3);
      write_csr(CSR_SEG0_TOTAL_BYTES, t0);
      write_csr(CSR_SEG0_BLOCK_BYTES, b0);
      write_csr(CSR_SEG0_BLOCK_BYTES + 3'd1, b1);
      write_csr(CSR_SEG0_TOTAL_BYTES + 3'd1, t1);
      write_csr(CSR_SEG0_BLOCK_BYTES + 3'd2, b2);
      write_csr(CSR_SEG0_TOTAL_BYTES + 3'd2, t2);
      write_csr(CSR_SEG0_TOTAL_BYTES + 3'd3, t3);
      write_csr(CSR_SEG0_BLOCK_BYTES + 3'd3, b3);
      @(negedge clock);
   endtask

   // Wait until every queued word is taken and every expected result is back.
   task automatic settle();
      do @(negedge clock); while (command_fifo.size() != 0 || start);
      do @(posedge clock); while (pending_replies.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) pending_replies.push_back(predict_allocator(active_cmd));
         if (!start || !busy) begin
            if (drain_hold && pending_replies.size() != 0) begin
               start <= 1'b0;
            end else begin
               drain_hold = 1'b0;
               if (command_fifo.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
                  active_cmd = command_fifo.pop_front();
                  // Now and then hold the next word until the block has drained.
                  drain_hold = ($urandom_range(63, 0) == 0);
                  start <= 1'b1;
                  req_func <= active_cmd.func;
                  req_request_bytes <= active_cmd.req_bytes;
                  req_free_handle <= active_cmd.handle;
               end else begin
                  start <= 1'b0;
               end
            end
         end
      end
   end

   // Results are sampled mid-cycle, where the strobe and fields are stable.
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: result word with nothing expected, handle %0d",
                        $realtime, rsp_result_handle);
         end else begin
            want_reply = pending_replies.pop_front();
            check_field("result_handle", want_reply.handle, rsp_result_handle);
            check_field("segment_index", 16'(want_reply.seg), 16'(rsp_segment_index));
            check_field("status", 16'(want_reply.status), 16'(rsp_status));
            check_field("in_use", want_reply.used, rsp_in_use);
            check_field("in_use_peak", want_reply.peak, rsp_in_use_peak);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < REG_SEGS; s++) begin
         blk_bytes[s] = BLOCK_RESET[s];
         tot_bytes[s] = 0;
      end
      clear_segments();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      gap_pct = 27;

      // Out of reset every segment is empty: exhausted, no fit, outside.
      command_fifo.push_back(alloc_word(16));
      command_fifo.push_back(alloc_word(200));
      command_fifo.push_back(free_word(1024));
      settle();

      set_layout(16, 32, 64, 128, 512, 1024, 2048, 4096);
      command_fifo.push_back(alloc_word(0));
      command_fifo.push_back(alloc_word(16));
      command_fifo.push_back(alloc_word(17));
      command_fifo.push_back(alloc_word(64));
      command_fifo.push_back(alloc_word(128));
      command_fifo.push_back(alloc_word(129));
      command_fifo.push_back(alloc_word(65535));
      command_fifo.push_back(free_word(0));
      command_fifo.push_back(free_word(65535));
      command_fifo.push_back(free_word(1023));
      command_fifo.push_back(free_word(1024));
      // A double free pushes the handle twice; both pops then return it.
      command_fifo.push_back(free_word(1024));
      command_fifo.push_back(alloc_word(16));
      command_fifo.push_back(alloc_word(16));
      command_fifo.push_back(free_word(1030));
      command_fifo.push_back(free_word(1087));
      command_fifo.push_back(free_word(1088));
      command_fifo.push_back(alloc_word(32));
      queue_random(190);
      settle();

      set_layout(8, 24, 200, 65535, 64, 240, 16000, 524287);
      queue_random(190);
      settle();

      // Block sizes under one granule never advance the pool; segment two is empty.
      set_layout(0, 5, 7, 9, 8, 16, 0, 80);
      command_fifo.push_back(alloc_word(0));
      command_fifo.push_back(alloc_word(0));
      command_fifo.push_back(alloc_word(3));
      command_fifo.push_back(alloc_word(6));
      queue_random(190);
      settle();

      // Segment zero covers all handles from its base up, so its pool saturates.
      set_layout(65535, 65535, 1000, 0, 524287, 524287, 524287, 524287);
      gap_pct = 78;
      repeat (10) command_fifo.push_back(alloc_word(1));
      queue_random(150);
      settle();

      set_layout(100, 50, 300, 2000, 800, 8, 3000, 40000);
      gap_pct = 78;
      queue_random(190);
      settle();

      set_layout(65535, 65535, 65535, 65535, 0, 0, 0, 0);
      gap_pct = 78;
      queue_random(50);
      settle();

      set_layout(16, 32, 64, 128, 128, 256, 512, 1024);
      gap_pct = 0;
      queue_random(190);
      settle();

      set_layout(8, 16, 4096, 65535, 524280, 1000, 8192, 524287);
      gap_pct = 0;
      queue_random(100);
      settle();

      // A zero-sized block hands out the same pool handle again and again.
      set_layout(0, 32, 64, 128, 8, 0, 0, 0);
      gap_pct = 0;
      repeat (20) command_fifo.push_back(alloc_word(0));
      command_fifo.push_back(free_word(1024));
      command_fifo.push_back(alloc_word(0));
      command_fifo.push_back(free_word(1024));
      settle();

      if (fault_count == 0 && pending_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sfba_pkg.sv
rtl/core/sfba_bound_unit.sv
rtl/core/sfba_link_ram.sv
rtl/core/segmented_fixed_block_allocator_core.sv
rtl/core/sfba_checker.sv
tb/tb_segmented_fixed_block_allocator_core.sv
